[hdl/bpjq_pkg.sv]
`default_nettype none

package bpjq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int ADDR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_EMPTY  = 2'd1,
        STS_FULL   = 2'd2,
        STS_BADPRI = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EQ_SCAN,
        S_EQ_CMP,
        S_HEAD,
        S_DQ_SCAN,
        S_DQ_MOVE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

[hdl/bounded_priority_job_queue_top.sv]
// enqueue walks from the tail past every held job with a larger priority number; dequeue
// shifts the rest toward the head; peek reads the head; rejected or unused ops go to done
// one word at a time: a new operation is taken only in idle; every step
// of the insert and shift walk goes through the single registered read port of the job ram
// a result word the receiver has not taken holds the block in done until it goes
// reset clears the job count and the control state; the job ram is not cleared
`default_nettype none

module bounded_priority_job_queue_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  job_priority,
    input  wire logic [31:0] job_payload,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [1:0]       status,
    output logic             out_valid,
    output logic [7:0]       out_priority,
    output logic [31:0]      out_payload,
    output logic [4:0]       count,
    output logic [4:0]       free_space,
    output logic             is_full,
    output logic             is_empty
);

    localparam int AW = bpjq_pkg::ADDR_W;
    localparam int CW = bpjq_pkg::CNT_W;
    localparam int PW = bpjq_pkg::PAYLOAD_BITS;

    // job ram, one write and one registered read per cycle
    logic [7:0]    prio_mem [bpjq_pkg::QUEUE_DEPTH];
    logic [PW-1:0] pay_mem  [bpjq_pkg::QUEUE_DEPTH];
    logic [7:0]    rd_prio_reg;
    logic [PW-1:0] rd_pay_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wprio;
    logic [PW-1:0] mem_wpay;

    bpjq_pkg::state_t  state_reg, state_next;
    bpjq_pkg::op_t     op_reg, op_next;
    logic [7:0]        pri_reg, pri_next;
    logic [PW-1:0]     pay_reg, pay_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     held_reg, held_next;

    bpjq_pkg::status_t wst_reg, wst_next;
    logic              whit_reg, whit_next;
    logic [7:0]        wprio_reg, wprio_next;
    logic [PW-1:0]     wpay_reg, wpay_next;

    logic              res_valid_reg, res_valid_next;
    bpjq_pkg::status_t status_reg, status_next;
    logic              hit_reg, hit_next;
    logic [7:0]        oprio_reg, oprio_next;
    logic [PW-1:0]     opay_reg, opay_next;
    logic [CW-1:0]     ocnt_reg, ocnt_next;

    logic              accept;
    logic              res_free;
    bpjq_pkg::op_t     in_op;
    logic [CW-1:0]     idx_plus1;

    assign in_ready  = (state_reg == bpjq_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_free  = !res_valid_reg || res_ready;
    assign in_op     = bpjq_pkg::op_t'(operation);
    assign idx_plus1 = CW'(idx_reg) + CW'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prio_mem[mem_waddr] <= mem_wprio;
            pay_mem[mem_waddr]  <= mem_wpay;
        end
        rd_prio_reg <= prio_mem[mem_raddr];
        rd_pay_reg  <= pay_mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpjq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        bpjq_pkg::OP_ENQ:
                        begin
                            if (job_priority == 8'd0 || held_reg == CW'(bpjq_pkg::QUEUE_DEPTH))
                                state_next = bpjq_pkg::S_DONE;
                            else
                                state_next = bpjq_pkg::S_EQ_SCAN;
                        end
                        bpjq_pkg::OP_DEQ, bpjq_pkg::OP_PEEK:
                        begin
                            if (held_reg == CW'(0))
                                state_next = bpjq_pkg::S_DONE;
                            else
                                state_next = bpjq_pkg::S_HEAD;
                        end
                        default: state_next = bpjq_pkg::S_DONE;
                    endcase
                end
            end
            bpjq_pkg::S_EQ_SCAN:
                state_next = (idx_reg == AW'(0)) ? bpjq_pkg::S_DONE : bpjq_pkg::S_EQ_CMP;
            bpjq_pkg::S_EQ_CMP:
                state_next = (rd_prio_reg > pri_reg) ? bpjq_pkg::S_EQ_SCAN : bpjq_pkg::S_DONE;
            bpjq_pkg::S_HEAD:
                state_next = (op_reg == bpjq_pkg::OP_PEEK) ? bpjq_pkg::S_DONE
                                                           : bpjq_pkg::S_DQ_SCAN;
            bpjq_pkg::S_DQ_SCAN:
                state_next = (idx_plus1 >= held_reg) ? bpjq_pkg::S_DONE : bpjq_pkg::S_DQ_MOVE;
            bpjq_pkg::S_DQ_MOVE:
                state_next = bpjq_pkg::S_DQ_SCAN;
            bpjq_pkg::S_DONE:
                state_next = res_free ? bpjq_pkg::S_IDLE : bpjq_pkg::S_DONE;
            default:
                state_next = bpjq_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_raddr      = '0;
        mem_wprio      = rd_prio_reg;
        mem_wpay       = rd_pay_reg;
        op_next        = op_reg;
        pri_next       = pri_reg;
        pay_next       = pay_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        wst_next       = wst_reg;
        whit_next      = whit_reg;
        wprio_next     = wprio_reg;
        wpay_next      = wpay_reg;
        res_valid_next = res_valid_reg && !res_ready;
        status_next    = status_reg;
        hit_next       = hit_reg;
        oprio_next     = oprio_reg;
        opay_next      = opay_reg;
        ocnt_next      = ocnt_reg;

        unique case (state_reg)
            bpjq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_op;
                    pri_next   = job_priority;
                    pay_next   = PW'(job_payload);
                    idx_next   = AW'(held_reg);
                    wst_next   = bpjq_pkg::STS_OK;
                    whit_next  = 1'b0;
                    wprio_next = '0;
                    wpay_next  = '0;
                    case (in_op)
                        bpjq_pkg::OP_ENQ:
                        begin
                            if (job_priority == 8'd0)
                                wst_next = bpjq_pkg::STS_BADPRI;
                            else if (held_reg == CW'(bpjq_pkg::QUEUE_DEPTH))
                                wst_next = bpjq_pkg::STS_FULL;
                        end
                        bpjq_pkg::OP_DEQ, bpjq_pkg::OP_PEEK:
                        begin
                            if (held_reg == CW'(0))
                                wst_next = bpjq_pkg::STS_EMPTY;
                        end
                        default: wst_next = bpjq_pkg::STS_OK;
                    endcase
                end
            end
            bpjq_pkg::S_EQ_SCAN:
            begin
                // walk from the tail toward the head
                mem_raddr = idx_reg - AW'(1);
                if (idx_reg == AW'(0))
                begin
                    mem_we    = 1'b1;
                    mem_wprio = pri_reg;
                    mem_wpay  = pay_reg;
                    held_next = held_reg + CW'(1);
                end
            end
            bpjq_pkg::S_EQ_CMP:
            begin
                mem_we = 1'b1;
                if (rd_prio_reg > pri_reg)
                    idx_next = idx_reg - AW'(1);
                else
                begin
                    // equal priority stays ahead of the new job
                    mem_wprio = pri_reg;
                    mem_wpay  = pay_reg;
                    held_next = held_reg + CW'(1);
                end
            end
            bpjq_pkg::S_HEAD:
            begin
                whit_next  = 1'b1;
                wprio_next = rd_prio_reg;
                wpay_next  = rd_pay_reg;
                idx_next   = '0;
            end
            bpjq_pkg::S_DQ_SCAN:
            begin
                mem_raddr = AW'(idx_plus1);
                if (idx_plus1 >= held_reg)
                    held_next = held_reg - CW'(1);
            end
            bpjq_pkg::S_DQ_MOVE:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + AW'(1);
            end
            bpjq_pkg::S_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = wst_reg;
                    hit_next       = whit_reg;
                    oprio_next     = wprio_reg;
                    opay_next      = wpay_reg;
                    ocnt_next      = held_reg;
                end
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpjq_pkg::S_IDLE;
            held_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pri_reg    <= pri_next;
        pay_reg    <= pay_next;
        idx_reg    <= idx_next;
        wst_reg    <= wst_next;
        whit_reg   <= whit_next;
        wprio_reg  <= wprio_next;
        wpay_reg   <= wpay_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        oprio_reg  <= oprio_next;
        opay_reg   <= opay_next;
        ocnt_reg   <= ocnt_next;
    end

    assign res_valid    = res_valid_reg;
    assign status       = 2'(status_reg);
    assign out_valid    = hit_reg;
    assign out_priority = oprio_reg;
    assign out_payload  = 32'(opay_reg);
    assign count        = 5'(ocnt_reg);
    assign free_space   = 5'(CW'(bpjq_pkg::QUEUE_DEPTH) - ocnt_reg);
    assign is_full      = (ocnt_reg == CW'(bpjq_pkg::QUEUE_DEPTH));
    assign is_empty     = (ocnt_reg == CW'(0));

`ifndef SYNTH
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(bpjq_pkg::QUEUE_DEPTH))
        else $error("job count above depth");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpjq_pkg::S_IDLE || state_reg == bpjq_pkg::S_DONE) |-> !mem_we)
        else $error("ram written outside a walk");

    a_held_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != $past(held_reg)) |-> (state_reg == bpjq_pkg::S_DONE))
        else $error("job count changed mid walk");

    a_hit_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && hit_reg) |-> (status_reg == bpjq_pkg::STS_OK))
        else $error("job returned with error status");

    a_result_loads_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == bpjq_pkg::S_DONE))
        else $error("result word raised outside done");
`endif

endmodule

`default_nettype wire
